// ===== design/sc2a_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2a_pkg: scan code to ASCII shared definitions
// Key codes, the character table and the letter ranges used by the set-1
// scan code decoder.
// ----------------------------------------------------------------------------
package sc2a_pkg;

	localparam logic [7:0] PREFIX_CODE = 8'hE0;
	localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT  = 7'h36;
	localparam logic [6:0] KEY_CTRL    = 7'h1D;
	localparam logic [6:0] KEY_ALT     = 7'h38;
	localparam logic [6:0] KEY_CAPS    = 7'h3A;
	localparam logic [6:0] TABLE_LEN   = 7'd59;

	typedef struct packed {
		logic [6:0] shifted;
		logic [6:0] plain;
	} char_entry_t;

	function automatic logic is_letter(input logic [6:0] code);
		return (code >= 7'h10 && code <= 7'h19) ||
		       (code >= 7'h1E && code <= 7'h26) ||
		       (code >= 7'h2C && code <= 7'h32);
	endfunction

	function automatic char_entry_t char_lookup(input logic [5:0] code);
		char_entry_t ent;
		case (code)
			6'h01: ent = {7'h1B, 7'h1B};
			6'h02: ent = {7'h21, 7'h31};
			6'h03: ent = {7'h40, 7'h32};
			6'h04: ent = {7'h23, 7'h33};
			6'h05: ent = {7'h24, 7'h34};
			6'h06: ent = {7'h25, 7'h35};
			6'h07: ent = {7'h5E, 7'h36};
			6'h08: ent = {7'h26, 7'h37};
			6'h09: ent = {7'h2A, 7'h38};
			6'h0A: ent = {7'h28, 7'h39};
			6'h0B: ent = {7'h29, 7'h30};
			6'h0C: ent = {7'h5F, 7'h2D};
			6'h0D: ent = {7'h2B, 7'h3D};
			6'h0E: ent = {7'h08, 7'h08};
			6'h0F: ent = {7'h09, 7'h09};
			6'h10: ent = {7'h51, 7'h71};
			6'h11: ent = {7'h57, 7'h77};
			6'h12: ent = {7'h45, 7'h65};
			6'h13: ent = {7'h52, 7'h72};
			6'h14: ent = {7'h54, 7'h74};
			6'h15: ent = {7'h59, 7'h79};
			6'h16: ent = {7'h55, 7'h75};
			6'h17: ent = {7'h49, 7'h69};
			6'h18: ent = {7'h4F, 7'h6F};
			6'h19: ent = {7'h50, 7'h70};
			6'h1A: ent = {7'h7B, 7'h5B};
			6'h1B: ent = {7'h7D, 7'h5D};
			6'h1C: ent = {7'h0D, 7'h0D};
			6'h1E: ent = {7'h41, 7'h61};
			6'h1F: ent = {7'h53, 7'h73};
			6'h20: ent = {7'h44, 7'h64};
			6'h21: ent = {7'h46, 7'h66};
			6'h22: ent = {7'h47, 7'h67};
			6'h23: ent = {7'h48, 7'h68};
			6'h24: ent = {7'h4A, 7'h6A};
			6'h25: ent = {7'h4B, 7'h6B};
			6'h26: ent = {7'h4C, 7'h6C};
			6'h27: ent = {7'h3A, 7'h3B};
			6'h28: ent = {7'h22, 7'h27};
			6'h29: ent = {7'h7E, 7'h60};
			6'h2B: ent = {7'h7C, 7'h5C};
			6'h2C: ent = {7'h5A, 7'h7A};
			6'h2D: ent = {7'h58, 7'h78};
			6'h2E: ent = {7'h43, 7'h63};
			6'h2F: ent = {7'h56, 7'h76};
			6'h30: ent = {7'h42, 7'h62};
			6'h31: ent = {7'h4E, 7'h6E};
			6'h32: ent = {7'h4D, 7'h6D};
			6'h33: ent = {7'h3C, 7'h2C};
			6'h34: ent = {7'h3E, 7'h2E};
			6'h35: ent = {7'h3F, 7'h2F};
			6'h37: ent = {7'h2A, 7'h2A};
			6'h39: ent = {7'h20, 7'h20};
			default: ent = {7'h00, 7'h00};
		endcase
		return ent;
	endfunction

endpackage

// ===== design/scan_code_to_ascii_top.sv =====
// ----------------------------------------------------------------------------
// scan_code_to_ascii_top: set-1 scan code to ASCII decoder
// An accepted scan byte is loaded into the input register, and its character
// is then loaded into the result register.
// Throughput: one scan byte per cycle, limited only by output stall.
// Reset clears the prefix, shift, ctrl, alt and caps flags and both valids.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] ascii_char,
	output logic       ctrl_held,
	output logic       alt_held
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        prefix_q;
	logic        shift_q;
	logic        ctrl_q;
	logic        alt_q;
	logic        caps_q;
	logic        out_valid_q;
	logic [6:0]  char_q;
	logic        ctrl_out_q;
	logic        alt_out_q;

	logic [6:0]  low;
	logic        is_pfx;
	logic        brk;
	logic        is_alt;
	logic        is_ctrl;
	logic        is_shift;
	logic        is_caps;
	logic        emit;
	logic        out_free;
	logic        s1_go;
	logic        col;
	sc2a_pkg::char_entry_t ent;

	always_comb begin
		low      = byte_s1[6:0];
		brk      = byte_s1[7];
		is_pfx   = (byte_s1 == sc2a_pkg::PREFIX_CODE);
		is_alt   = (low == sc2a_pkg::KEY_ALT);
		is_ctrl  = (low == sc2a_pkg::KEY_CTRL);
		is_shift = !prefix_q && (low == sc2a_pkg::KEY_LSHIFT || low == sc2a_pkg::KEY_RSHIFT);
		is_caps  = !prefix_q && (low == sc2a_pkg::KEY_CAPS);
		emit     = !is_pfx && !brk && !prefix_q && !is_alt && !is_ctrl && !is_shift &&
		           !is_caps && (low < sc2a_pkg::TABLE_LEN);
		ent      = sc2a_pkg::char_lookup(low[5:0]);
		col      = shift_q ^ (sc2a_pkg::is_letter(low) & caps_q);
		out_free = !out_valid_q || !out_stall;
		s1_go    = valid_s1 && (!emit || out_free);
		in_stall = valid_s1 && !s1_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
			caps_q   <= 1'b0;
		end else if (s1_go) begin
			prefix_q <= is_pfx;
			if (!is_pfx) begin
				if (is_alt) begin
					alt_q <= !brk;
				end
				if (is_ctrl) begin
					ctrl_q <= !brk;
				end
				if (is_shift) begin
					shift_q <= !brk;
				end
				if (is_caps && !brk) begin
					caps_q <= !caps_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_go && emit) begin
			char_q     <= col ? ent.shifted : ent.plain;
			ctrl_out_q <= ctrl_q;
			alt_out_q  <= alt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign ctrl_held  = ctrl_out_q;
	assign alt_held   = alt_out_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no request in the input register");

	a_prefix_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_pfx) |=> prefix_q)
		else $error("prefix byte did not set the prefix flag");

	a_prefix_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !is_pfx) |=> !prefix_q)
		else $error("prefix flag survived a following byte");

	a_emit_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && emit) |=> out_valid_q)
		else $error("character request was lost before the output register");

endmodule
